// ----- rtl/pareto_archive_update_macros.svh -----
// ----------------------------------------------------------------------------
// Pareto archive update: assertion macros
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef PARETO_ARCHIVE_UPDATE_MACROS_SVH
`define PARETO_ARCHIVE_UPDATE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Plain condition, checked at every clock edge outside reset
`define PAU_ASSERT(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("pau assertion failed");

// Same-cycle implication
`define PAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pau assertion failed");

// Next-cycle implication
`define PAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pau assertion failed");

`else

`define PAU_ASSERT(lbl, clk, rstn, cond)
`define PAU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/pau_pkg.sv -----
// ----------------------------------------------------------------------------
// Pareto archive update package
// Shared types, widths and status codes of the archive block.
// ----------------------------------------------------------------------------
package pau_pkg;

  // Field widths
  localparam int unsigned ObjW            = 32;
  localparam int unsigned NumObj          = 4;
  localparam int unsigned IndexW          = 6;
  localparam int unsigned CountW          = 7;
  localparam int unsigned ArchiveDepthDef = 64;

  // Transaction kinds
  localparam logic KindOffer = 1'b0;
  localparam logic KindRead  = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADDED        = 3'd0,
    ST_DOMINATED    = 3'd1,
    ST_DUPLICATE    = 3'd2,
    ST_FULL         = 3'd3,
    ST_READ_OK      = 3'd4,
    ST_OUT_OF_RANGE = 3'd5
  } status_e;

  // Input transaction payload
  typedef struct packed {
    logic              kind;
    logic [ObjW-1:0]   obj_distance;
    logic [ObjW-1:0]   obj_vehicles;
    logic [ObjW-1:0]   obj_balance;
    logic [ObjW-1:0]   obj_waiting;
    logic [ObjW-1:0]   tour_signature;
    logic [IndexW-1:0] entry_index;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic [2:0]        status;
    logic [CountW-1:0] removed_count;
    logic [CountW-1:0] archive_count;
    logic [ObjW-1:0]   out_distance;
    logic [ObjW-1:0]   out_vehicles;
    logic [ObjW-1:0]   out_balance;
    logic [ObjW-1:0]   out_waiting;
    logic [ObjW-1:0]   out_signature;
  } out_item_t;

  // One archive entry: objectives in order distance, vehicles, balance, waiting
  typedef struct packed {
    logic [NumObj-1:0][ObjW-1:0] obj;
    logic [ObjW-1:0]             sig;
  } entry_t;

  // Dominance compare result
  typedef struct packed {
    logic ent_dom;   // stored entry dominates candidate
    logic cand_dom;  // candidate dominates stored entry
    logic sig_eq;    // same tour signature
  } cmp_res_t;

endpackage

// ----- rtl/pau_chan_if.sv -----
// ----------------------------------------------------------------------------
// Pareto archive update channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface pau_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/pau_dom_cmp.sv -----
// ----------------------------------------------------------------------------
// Pareto archive dominance compare
// Shared compare unit: checks a stored entry against the candidate.
// ----------------------------------------------------------------------------
module pau_dom_cmp (
  input  pau_pkg::entry_t   ent_i,
  input  pau_pkg::entry_t   cand_i,
  output pau_pkg::cmp_res_t res_o
);

  logic [pau_pkg::NumObj-1:0] ent_le;
  logic [pau_pkg::NumObj-1:0] cand_le;
  logic [pau_pkg::NumObj-1:0] obj_ne;

  // Per-objective magnitude compares
  always_comb begin
    for (int k = 0; k < pau_pkg::NumObj; k++) begin
      ent_le[k]  = (ent_i.obj[k] <= cand_i.obj[k]);
      cand_le[k] = (cand_i.obj[k] <= ent_i.obj[k]);
      obj_ne[k]  = (ent_i.obj[k] != cand_i.obj[k]);
    end
  end

  // Dominance: all no worse and vectors differ
  assign res_o.ent_dom  = (&ent_le) & (|obj_ne);
  assign res_o.cand_dom = (&cand_le) & (|obj_ne);
  assign res_o.sig_eq   = (ent_i.sig == cand_i.sig);

endmodule

// ----- rtl/pau_entry_ram.sv -----
// ----------------------------------------------------------------------------
// Pareto archive entry memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pau_entry_ram #(
  parameter int unsigned Depth = pau_pkg::ArchiveDepthDef,
  parameter int unsigned AddrW = 6
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  pau_pkg::entry_t    wdata_i,
  input  logic [AddrW-1:0]   raddr_i,
  output pau_pkg::entry_t    rdata_o
);

  pau_pkg::entry_t mem [Depth];
  pau_pkg::entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pareto_archive_update.sv -----
// ----------------------------------------------------------------------------
// Pareto archive update
// Ordered archive of non-dominated solutions with in-place compaction.
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    pau_pkg::in_item_t  (offer or read)
//   out_o    out  valid / ready    pau_pkg::out_item_t (one per input)
//
// An offer issues the first memory read when it is taken, passes each held
// entry in turn through the shared compare unit, then takes a finish step.
// A read reports from the registered read data of the single read port.
// After reset the archive is empty; the entry memory needs no clearing.
// A result waits in the output register; a new transaction is taken
// meanwhile, and its finish step holds until the output register is free.
// ----------------------------------------------------------------------------
`include "pareto_archive_update_macros.svh"

module pareto_archive_update #(
  parameter int unsigned ARCHIVE_DEPTH = pau_pkg::ArchiveDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pau_chan_if.sink     in_i,
  pau_chan_if.source   out_o
);

  localparam int unsigned AddrW = (ARCHIVE_DEPTH > 1) ? $clog2(ARCHIVE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(ARCHIVE_DEPTH + 1);
  localparam int unsigned IdxW  = pau_pkg::IndexW;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EV    = 4'b0010,
    S_FIN   = 4'b0100,
    S_RDOUT = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     rd_q, rd_d;
  logic [CntW-1:0]     wr_q, wr_d;
  logic [CntW-1:0]     removed_q, removed_d;
  logic                rej_q, rej_d;
  logic                rdok_q, rdok_d;
  pau_pkg::status_e    stat_q, stat_d;
  pau_pkg::entry_t     cand_q, cand_d;
  logic                out_valid_q, out_valid_d;
  pau_pkg::out_item_t  out_q, out_d;

  logic                accept;
  logic                out_free;
  logic [CntW-1:0]     rd_inc;
  logic [AddrW+IdxW-1:0] idx_ext;
  logic [AddrW-1:0]    idx_addr;
  logic                idx_in_range;

  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  pau_pkg::entry_t     ram_wdata;
  logic [AddrW-1:0]    ram_raddr;
  pau_pkg::entry_t     ram_rdata;
  pau_pkg::cmp_res_t   cmp_res;

  // Entry memory and shared compare unit
  pau_entry_ram #(
    .Depth (ARCHIVE_DEPTH),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pau_dom_cmp u_cmp (
    .ent_i  (ram_rdata),
    .cand_i (cand_q),
    .res_o  (cmp_res)
  );

  // Handshake
  assign in_i.ready    = (state_q == S_IDLE);
  assign accept        = in_i.valid && in_i.ready;
  assign out_free      = !out_valid_q || out_o.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Index helpers
  assign rd_inc       = rd_q + 1'b1;
  assign idx_ext      = {{AddrW{1'b0}}, in_i.payload.entry_index};
  assign idx_addr     = idx_ext[AddrW-1:0];
  assign idx_in_range = ({{CntW{1'b0}}, in_i.payload.entry_index}
                         < {{IdxW{1'b0}}, cnt_q});

  // Sequencer
  always_comb begin
    logic keep;
    keep        = 1'b1;
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    removed_d   = removed_q;
    rej_d       = rej_q;
    rdok_d      = rdok_q;
    stat_d      = stat_q;
    cand_d      = cand_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = wr_q[AddrW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.payload.kind == pau_pkg::KindRead) begin
            rdok_d    = idx_in_range;
            rd_d      = idx_in_range ? CntW'(idx_addr) : '0;
            ram_raddr = idx_in_range ? idx_addr : '0;
            state_d   = S_RDOUT;
          end else begin
            cand_d.obj[0] = in_i.payload.obj_distance;
            cand_d.obj[1] = in_i.payload.obj_vehicles;
            cand_d.obj[2] = in_i.payload.obj_balance;
            cand_d.obj[3] = in_i.payload.obj_waiting;
            cand_d.sig    = in_i.payload.tour_signature;
            rd_d          = '0;
            wr_d          = '0;
            removed_d     = '0;
            rej_d         = 1'b0;
            stat_d        = pau_pkg::ST_ADDED;
            state_d       = (cnt_q == '0) ? S_FIN : S_EV;
          end
        end
      end

      // One entry per cycle: classify, compact survivors, fetch next
      S_EV: begin
        if (!rej_q) begin
          if (cmp_res.ent_dom) begin
            rej_d  = 1'b1;
            stat_d = pau_pkg::ST_DOMINATED;
          end else if (cmp_res.sig_eq) begin
            rej_d  = 1'b1;
            stat_d = pau_pkg::ST_DUPLICATE;
          end else if (cmp_res.cand_dom) begin
            keep      = 1'b0;
            removed_d = removed_q + 1'b1;
          end
        end
        if (keep) begin
          ram_we = 1'b1;
          wr_d   = wr_q + 1'b1;
        end
        rd_d = rd_inc;
        if (rd_inc == cnt_q) begin
          state_d = S_FIN;
        end else begin
          ram_raddr = rd_inc[AddrW-1:0];
        end
      end

      // Append candidate unless rejected or the archive is full, and report
      S_FIN: begin
        if (out_free) begin
          out_d.status = stat_q;
          cnt_d        = wr_q;
          if (!rej_q) begin
            if (wr_q < CntW'(ARCHIVE_DEPTH)) begin
              ram_we       = 1'b1;
              ram_wdata    = cand_q;
              cnt_d        = wr_q + 1'b1;
              out_d.status = pau_pkg::ST_ADDED;
            end else begin
              out_d.status = pau_pkg::ST_FULL;
            end
          end
          out_d.removed_count = pau_pkg::CountW'(removed_q);
          out_d.archive_count = pau_pkg::CountW'(cnt_d);
          out_d.out_distance  = '0;
          out_d.out_vehicles  = '0;
          out_d.out_balance   = '0;
          out_d.out_waiting   = '0;
          out_d.out_signature = '0;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end

      // Read data is ready; hold the address while the output is busy
      S_RDOUT: begin
        ram_raddr = rd_q[AddrW-1:0];
        if (out_free) begin
          out_d.status        = rdok_q ? pau_pkg::ST_READ_OK : pau_pkg::ST_OUT_OF_RANGE;
          out_d.removed_count = '0;
          out_d.archive_count = pau_pkg::CountW'(cnt_q);
          out_d.out_distance  = rdok_q ? ram_rdata.obj[0] : '0;
          out_d.out_vehicles  = rdok_q ? ram_rdata.obj[1] : '0;
          out_d.out_balance   = rdok_q ? ram_rdata.obj[2] : '0;
          out_d.out_waiting   = rdok_q ? ram_rdata.obj[3] : '0;
          out_d.out_signature = rdok_q ? ram_rdata.sig : '0;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    rd_q      <= rd_d;
    wr_q      <= wr_d;
    removed_q <= removed_d;
    rej_q     <= rej_d;
    rdok_q    <= rdok_d;
    stat_q    <= stat_d;
    cand_q    <= cand_d;
    out_q     <= out_d;
  end

  // Assertions
  `PAU_ASSERT_IMP(a_wr_behind_rd, clk_i, rst_ni, state_q == S_EV, wr_q <= rd_q)
  `PAU_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(ARCHIVE_DEPTH))
  `PAU_ASSERT_IMP(a_fin_balance, clk_i, rst_ni, state_q == S_FIN, CntW'(removed_q + wr_q) == cnt_q)
  `PAU_ASSERT_NEXT(a_result_out, clk_i, rst_ni, (state_q == S_FIN || state_q == S_RDOUT) && out_free, out_valid_q && state_q == S_IDLE)

endmodule
